// ===== sv/patch_to_canvas_address_defines.svh =====
// Assertion macros for the patch-to-canvas address mapper.
`ifndef PATCH_TO_CANVAS_ADDRESS_DEFINES_SVH
`define PATCH_TO_CANVAS_ADDRESS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define P2C_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("p2c assertion failed");
`define P2C_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("p2c assertion failed");
`else
`define P2C_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define P2C_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/p2c_pkg.sv =====
// Shared types and constants of the patch-to-canvas address mapper.
`timescale 1ns / 1ps
package p2c_pkg;
	localparam int CANVAS_MAX_DEF  = 4096;
	localparam int OCC_RES_MAX_DEF = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_W           = 13;
	localparam int CRD_W           = 12;
	localparam int RES_W           = 7;
	localparam int SUM_W           = 14;  // size plus origin
	localparam int PROD_W          = 21;  // resolution times a sum
	localparam int XW              = 23;  // signed working width of a coordinate
	localparam int IDX_OUT_W       = 24;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_BLOCK = 1'b1
	} op_e;

	typedef enum logic [3:0] {
		ORI_DEFAULT = 4'd0,
		ORI_ROT90   = 4'd1,
		ORI_ROT180  = 4'd2,
		ORI_ROT270  = 4'd3,
		ORI_MIRROR  = 4'd4,
		ORI_MROT90  = 4'd5,
		ORI_MROT180 = 4'd6,
		ORI_MROT270 = 4'd7,
		ORI_SWAP    = 4'd8
	} ori_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_W  = 3'd0,
		REG_FRAME_H  = 3'd1,
		REG_GRID_W   = 3'd2,
		REG_GRID_H   = 3'd3
	} reg_idx_e;

	typedef struct packed {
		logic              opcode;
		logic [CRD_W-1:0]  local_u;
		logic [CRD_W-1:0]  local_v;
		logic [CRD_W-1:0]  origin_u_blocks;
		logic [CRD_W-1:0]  origin_v_blocks;
		logic [CFG_W-1:0]  width_blocks;
		logic [CFG_W-1:0]  height_blocks;
		logic [3:0]        orientation;
		logic [RES_W-1:0]  blk_res;
	} cmd_t;

	typedef struct packed {
		logic [CRD_W-1:0]     canvas_x;
		logic [CRD_W-1:0]     canvas_y;
		logic [IDX_OUT_W-1:0] linear_index;
		logic                 valid_res;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] frame_width;
		logic [CFG_W-1:0] frame_height;
		logic [CFG_W-1:0] block_grid_width;
		logic [CFG_W-1:0] block_grid_height;
	} cfg_t;
endpackage

// ===== sv/patch_to_canvas_address.sv =====
// Top level of the patch-to-canvas address mapper: four-stage mapping pipeline.
// Each transferred command passes the stage registers s1 to s4 and then shows its
// result with done high; every command gives exactly one result.
// Throughput: one command per cycle; busy stays low, so start may be held high.
// Results cannot be held off: done is high in each cycle that holds a result.
// Reset clears the stage valid bits and loads the canvas registers with
// 1024 x 1024 pixels and 64 x 64 blocks.
`timescale 1ns / 1ps
`include "patch_to_canvas_address_defines.svh"
module patch_to_canvas_address import p2c_pkg::*; #(
	parameter int CANVAS_MAX  = CANVAS_MAX_DEF,
	parameter int OCC_RES_MAX = OCC_RES_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	// Canvas dimensions are limited to CANVAS_MAX, so this width holds them.
	localparam int CW_W  = $clog2(CANVAS_MAX + 1);
	localparam int IDX_W = 2 * CW_W + 1;

	cfg_t cfg;

	p2c_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The pipeline never stalls, so a command is taken in every cycle.
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// Stage 1: pick the canvas of the mode, clamp the resolution and
	// form the size-plus-origin sums that the flipped axes need.
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] dim_w_c, dim_h_c;
	logic [CW_W-1:0]  cw_c, ch_c;
	logic [RES_W-1:0] res_c;

	always_comb begin
		if (cmd.opcode == OP_BLOCK) begin
			dim_w_c = cfg.block_grid_width;
			dim_h_c = cfg.block_grid_height;
			res_c   = RES_W'(1);
		end else begin
			dim_w_c = cfg.frame_width;
			dim_h_c = cfg.frame_height;
			res_c   = (int'(cmd.blk_res) > OCC_RES_MAX) ?
				RES_W'(OCC_RES_MAX) : cmd.blk_res;
		end
		cw_c = (int'(dim_w_c) > CANVAS_MAX) ? CW_W'(CANVAS_MAX) : CW_W'(dim_w_c);
		ch_c = (int'(dim_h_c) > CANVAS_MAX) ? CW_W'(CANVAS_MAX) : CW_W'(dim_h_c);
	end

	logic             valid_s1;
	logic [CRD_W-1:0] u_s1, v_s1, u0_s1, v0_s1;
	logic [SUM_W-1:0] swu_s1, shu_s1, swv_s1, shv_s1;
	logic [3:0]       ori_s1;
	logic [RES_W-1:0] res_s1;
	logic [CW_W-1:0]  cw_s1, ch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		u_s1   <= cmd.local_u;
		v_s1   <= cmd.local_v;
		u0_s1  <= cmd.origin_u_blocks;
		v0_s1  <= cmd.origin_v_blocks;
		swu_s1 <= SUM_W'(cmd.width_blocks) + SUM_W'(cmd.origin_u_blocks);
		shu_s1 <= SUM_W'(cmd.height_blocks) + SUM_W'(cmd.origin_u_blocks);
		swv_s1 <= SUM_W'(cmd.width_blocks) + SUM_W'(cmd.origin_v_blocks);
		shv_s1 <= SUM_W'(cmd.height_blocks) + SUM_W'(cmd.origin_v_blocks);
		ori_s1 <= cmd.orientation;
		res_s1 <= res_c;
		cw_s1  <= cw_c;
		ch_s1  <= ch_c;
	end

	// ---------------------------------------------------------------
	// Stage 2: scale origins and flip extents by the resolution.
	// Six small products, each 14 x 7 bits at most.
	// ---------------------------------------------------------------
	logic              valid_s2;
	logic [CRD_W-1:0]  u_s2, v_s2;
	logic [PROD_W-1:0] bx_s2, by_s2, pfu_s2, pfvx_s2, pfuy_s2, pfvy_s2;
	logic [3:0]        ori_s2;
	logic [CW_W-1:0]   cw_s2, ch_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		u_s2    <= u_s1;
		v_s2    <= v_s1;
		bx_s2   <= PROD_W'(u0_s1) * PROD_W'(res_s1);
		by_s2   <= PROD_W'(v0_s1) * PROD_W'(res_s1);
		pfu_s2  <= PROD_W'(swu_s1) * PROD_W'(res_s1);
		pfvx_s2 <= PROD_W'(shu_s1) * PROD_W'(res_s1);
		pfuy_s2 <= PROD_W'(swv_s1) * PROD_W'(res_s1);
		pfvy_s2 <= PROD_W'(shv_s1) * PROD_W'(res_s1);
		ori_s2  <= ori_s1;
		cw_s2   <= cw_s1;
		ch_s2   <= ch_s1;
	end

	// ---------------------------------------------------------------
	// Stage 3: form the candidate coordinates, select by orientation
	// and check against the canvas. Candidates are two's complement in
	// XW bits; a flipped axis can go negative.
	// ---------------------------------------------------------------
	logic [XW-1:0] ux_c, vx_c, uy_c, vy_c, fu_c, fvx_c, fuy_c, fvy_c;
	logic [XW-1:0] x_c, y_c;
	logic          known_c, ok_c;

	always_comb begin
		ux_c  = XW'(u_s2) + XW'(bx_s2);
		vx_c  = XW'(v_s2) + XW'(bx_s2);
		uy_c  = XW'(u_s2) + XW'(by_s2);
		vy_c  = XW'(v_s2) + XW'(by_s2);
		fu_c  = XW'(pfu_s2) - XW'(u_s2) - XW'(1);
		fvx_c = XW'(pfvx_s2) - XW'(v_s2) - XW'(1);
		fuy_c = XW'(pfuy_s2) - XW'(u_s2) - XW'(1);
		fvy_c = XW'(pfvy_s2) - XW'(v_s2) - XW'(1);
		known_c = 1'b1;
		x_c = '0;
		y_c = '0;
		case (ori_s2)
			ORI_DEFAULT: begin
				x_c = ux_c;
				y_c = vy_c;
			end
			ORI_ROT90: begin
				x_c = fvx_c;
				y_c = uy_c;
			end
			ORI_ROT180: begin
				x_c = fu_c;
				y_c = fvy_c;
			end
			ORI_ROT270: begin
				x_c = vx_c;
				y_c = fuy_c;
			end
			ORI_MIRROR: begin
				x_c = fu_c;
				y_c = vy_c;
			end
			ORI_MROT90: begin
				x_c = fvx_c;
				y_c = fuy_c;
			end
			ORI_MROT180: begin
				x_c = ux_c;
				y_c = fvy_c;
			end
			ORI_MROT270, ORI_SWAP: begin
				// transpose: both map u to rows and v to columns
				x_c = vx_c;
				y_c = uy_c;
			end
			default: begin
				known_c = 1'b0;
			end
		endcase
		ok_c = known_c
			&& !x_c[XW-1] && (x_c[XW-2:0] < (XW-1)'(cw_s2))
			&& !y_c[XW-1] && (y_c[XW-2:0] < (XW-1)'(ch_s2));
	end

	logic            valid_s3, ok_s3;
	logic [CW_W-1:0] x_s3, y_s3, cw_s3, ch_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Zero the coordinates of an invalid result here so that the index
	// product below comes out zero as well.
	always_ff @(posedge clk) begin
		ok_s3 <= ok_c;
		x_s3  <= ok_c ? CW_W'(x_c) : '0;
		y_s3  <= ok_c ? CW_W'(y_c) : '0;
		cw_s3 <= cw_s2;
		ch_s3 <= ch_s2;
	end

	// ---------------------------------------------------------------
	// Stage 4: row-major index and the result register.
	// ---------------------------------------------------------------
	logic [IDX_W-1:0] idx_c;
	logic             valid_s4;
	result_t          result_s4;

	assign idx_c = IDX_W'(y_s3) * IDX_W'(cw_s3) + IDX_W'(x_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_s4.canvas_x     <= CRD_W'(x_s3);
		result_s4.canvas_y     <= CRD_W'(y_s3);
		result_s4.linear_index <= IDX_OUT_W'(idx_c);
		result_s4.valid_res    <= ok_s3;
	end

	assign done   = valid_s4;
	assign result = result_s4;

	`P2C_ASSERT_IMP(a_latency, clk, arst_n, start && !busy, ##4 done)
	`P2C_ASSERT_IMP(a_ok_in_canvas, clk, arst_n, valid_s3 && ok_s3, (x_s3 < cw_s3) && (y_s3 < ch_s3))
	`P2C_ASSERT_NXT(a_unknown_ori, clk, arst_n, valid_s2 && (ori_s2 > ORI_SWAP), !ok_s3)
	`P2C_ASSERT_IMP(a_invalid_zero, clk, arst_n, done && !result.valid_res, (result.canvas_x == '0) && (result.canvas_y == '0) && (result.linear_index == '0))
endmodule

// ===== sv/p2c_cfg_regs.sv =====
// Configuration register file of the patch-to-canvas address mapper.
`timescale 1ns / 1ps
module p2c_cfg_regs import p2c_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width       <= CFG_W'(1024);
			cfg_q.frame_height      <= CFG_W'(1024);
			cfg_q.block_grid_width  <= CFG_W'(64);
			cfg_q.block_grid_height <= CFG_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_W: cfg_q.frame_width       <= cfg_data;
				REG_FRAME_H: cfg_q.frame_height      <= cfg_data;
				REG_GRID_W:  cfg_q.block_grid_width  <= cfg_data;
				REG_GRID_H:  cfg_q.block_grid_height <= cfg_data;
				default: ;  // drop writes to unmapped indexes
			endcase
		end
	end
endmodule

// ===== verif/canvas_map_checker.sv =====
// Checker that predicts canvas addresses for each command transfer and compares results.
`timescale 1ns / 1ps
module canvas_map_checker import p2c_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  cmd_t                 cmd,
	input  logic                 done,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	cfg_t    canvas_regs;
	result_t expected_addr_q[$];
	int      errs;

	function automatic longint canvas_dim(logic [CFG_W-1:0] v);
		return (v > CANVAS_MAX_DEF) ? longint'(CANVAS_MAX_DEF) : longint'(v);
	endfunction

	function automatic result_t map_to_canvas(cmd_t c, cfg_t r);
		longint  u, v, u0, v0, sw, sh, res, cw, ch, x, y, idx;
		bit      ok;
		result_t o;
		u   = longint'(c.local_u);
		v   = longint'(c.local_v);
		u0  = longint'(c.origin_u_blocks);
		v0  = longint'(c.origin_v_blocks);
		sw  = longint'(c.width_blocks);
		sh  = longint'(c.height_blocks);
		res = longint'(c.blk_res);
		// saturate the resolution; zero is kept and collapses origin and size
		if (res > OCC_RES_MAX_DEF)
			res = longint'(OCC_RES_MAX_DEF);
		if (c.opcode == OP_BLOCK) begin
			res = 1;
			cw  = canvas_dim(r.block_grid_width);
			ch  = canvas_dim(r.block_grid_height);
		end else begin
			cw = canvas_dim(r.frame_width);
			ch = canvas_dim(r.frame_height);
		end
		ok = 1'b1;
		x  = 0;
		y  = 0;
		case (c.orientation)
			ORI_DEFAULT: begin
				x = u + u0 * res;
				y = v + v0 * res;
			end
			ORI_ROT90: begin
				x = res * (sh + u0) - 1 - v;
				y = u + v0 * res;
			end
			ORI_ROT180: begin
				x = res * (sw + u0) - 1 - u;
				y = res * (sh + v0) - 1 - v;
			end
			ORI_ROT270: begin
				x = v + u0 * res;
				y = res * (sw + v0) - 1 - u;
			end
			ORI_MIRROR: begin
				x = res * (sw + u0) - 1 - u;
				y = v + v0 * res;
			end
			ORI_MROT90: begin
				x = res * (sh + u0) - 1 - v;
				y = res * (sw + v0) - 1 - u;
			end
			ORI_MROT180: begin
				x = u + u0 * res;
				y = res * (sh + v0) - 1 - v;
			end
			ORI_MROT270, ORI_SWAP: begin
				x = v + u0 * res;
				y = u + v0 * res;
			end
			default: ok = 1'b0;
		endcase
		if (ok && (x < 0 || y < 0 || x >= cw || y >= ch))
			ok = 1'b0;
		o = '0;
		if (ok) begin
			idx            = y * cw + x;
			o.canvas_x     = x[CRD_W-1:0];
			o.canvas_y     = y[CRD_W-1:0];
			o.linear_index = idx[IDX_OUT_W-1:0];
			o.valid_res    = 1'b1;
		end
		return o;
	endfunction

	task automatic field_mismatch(string name, logic [IDX_OUT_W-1:0] exp_v,
			logic [IDX_OUT_W-1:0] act_v);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			canvas_regs <= '{13'd1024, 13'd1024, 13'd64, 13'd64};
			expected_addr_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_addr_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
					errs++;
				end else begin
					want = expected_addr_q.pop_front();
					if (result.canvas_x !== want.canvas_x)
						field_mismatch("canvas_x", IDX_OUT_W'(want.canvas_x),
							IDX_OUT_W'(result.canvas_x));
					if (result.canvas_y !== want.canvas_y)
						field_mismatch("canvas_y", IDX_OUT_W'(want.canvas_y),
							IDX_OUT_W'(result.canvas_y));
					if (result.linear_index !== want.linear_index)
						field_mismatch("linear_index", want.linear_index, result.linear_index);
					if (result.valid_res !== want.valid_res)
						field_mismatch("valid_res", IDX_OUT_W'(want.valid_res),
							IDX_OUT_W'(result.valid_res));
				end
			end
			// predict with the registers as they stand before any write at this edge
			if (start && !busy)
				expected_addr_q.insert(expected_addr_q.size(),
					map_to_canvas(cmd, canvas_regs));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_W: canvas_regs.frame_width       <= cfg_data;
					REG_FRAME_H: canvas_regs.frame_height      <= cfg_data;
					REG_GRID_W:  canvas_regs.block_grid_width  <= cfg_data;
					REG_GRID_H:  canvas_regs.block_grid_height <= cfg_data;
					default: ;
				endcase
			end
			fail_count <= errs;
			pending    <= expected_addr_q.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// Top of the testbench: drives commands and register writes, and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
	import p2c_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 147;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	cmd_t                 cmd       = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_W;
	logic [CFG_W-1:0]     cfg_data  = '0;
	int                   fail_count;
	int                   pending;

	// Copy of the canvas setting, used only to shape well-formed patches.
	cfg_t        cur_cfg = '{13'd1024, 13'd1024, 13'd64, 13'd64};
	bit          idle_on = 1'b1;
	int unsigned stall_cycles = 0;

	patch_to_canvas_address dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	canvas_map_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: end the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	function automatic int dim_limit(logic [CFG_W-1:0] v);
		return (v > CANVAS_MAX_DEF) ? CANVAS_MAX_DEF : int'(v);
	endfunction

	function automatic cmd_t mk_cmd(op_e op, int u, int v, int u0, int v0, int sw, int sh,
			int ori, int res);
		cmd_t c;
		c.opcode          = op;
		c.local_u         = CRD_W'(u);
		c.local_v         = CRD_W'(v);
		c.origin_u_blocks = CRD_W'(u0);
		c.origin_v_blocks = CRD_W'(v0);
		c.width_blocks    = CFG_W'(sw);
		c.height_blocks   = CFG_W'(sh);
		c.orientation     = 4'(ori);
		c.blk_res         = RES_W'(res);
		return c;
	endfunction

	// Noise: every field random over its full width.
	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.opcode          = 1'($urandom);
		c.local_u         = CRD_W'($urandom);
		c.local_v         = CRD_W'($urandom);
		c.origin_u_blocks = CRD_W'($urandom);
		c.origin_v_blocks = CRD_W'($urandom);
		c.width_blocks    = CFG_W'($urandom);
		c.height_blocks   = CFG_W'($urandom);
		c.orientation     = 4'($urandom);
		c.blk_res         = RES_W'($urandom);
		return c;
	endfunction

	// Well-formed point: a patch that fits the canvas under every rotation,
	// with the local coordinate inside the patch, so most results are valid.
	function automatic cmd_t patch_point(cfg_t r);
		cmd_t c;
		bit   blk;
		int   res_eff, cw, ch, bw, bh, smax, s, sw, sh;
		blk = 1'($urandom_range(1));
		c.opcode = blk ? OP_BLOCK : OP_PIXEL;
		c.blk_res = RES_W'($urandom_range(1, OCC_RES_MAX_DEF));
		if ($urandom_range(19) == 0)
			c.blk_res = RES_W'($urandom_range(0, 127));
		res_eff = blk ? 1 : ((c.blk_res > OCC_RES_MAX_DEF) ?
			OCC_RES_MAX_DEF : int'(c.blk_res));
		cw = blk ? dim_limit(r.block_grid_width) : dim_limit(r.frame_width);
		ch = blk ? dim_limit(r.block_grid_height) : dim_limit(r.frame_height);
		if (res_eff == 0 || cw < res_eff || ch < res_eff)
			return noise_cmd();
		bw = cw / res_eff;
		bh = ch / res_eff;
		smax = (bw < bh) ? bw : bh;
		// keep most patches small so origins spread over the whole canvas
		if ($urandom_range(3) != 0 && smax > 12)
			smax = 12;
		s  = $urandom_range(1, smax);
		sw = $urandom_range(1, s);
		sh = $urandom_range(1, s);
		c.width_blocks    = CFG_W'(sw);
		c.height_blocks   = CFG_W'(sh);
		c.origin_u_blocks = CRD_W'($urandom_range(0, bw - s));
		c.origin_v_blocks = CRD_W'($urandom_range(0, bh - s));
		c.local_u         = CRD_W'($urandom_range(0, sw * res_eff - 1));
		c.local_v         = CRD_W'($urandom_range(0, sh * res_eff - 1));
		c.orientation     = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) :
			4'($urandom_range(ORI_DEFAULT, ORI_SWAP));
		return c;
	endfunction

	// Present one command at the falling edge and hold it until transfer.
	task automatic send_cmd(cmd_t c);
		if (idle_on)
			while ($urandom_range(99) < 27) begin
				start <= 1'b0;
				@(negedge clk);
			end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] d);
		if (idle_on)
			while ($urandom_range(99) < 27)
				@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_W: cur_cfg.frame_width       = d;
			REG_FRAME_H: cur_cfg.frame_height      = d;
			REG_GRID_W:  cur_cfg.block_grid_width  = d;
			REG_GRID_H:  cur_cfg.block_grid_height = d;
			default: ;
		endcase
	endtask

	// Drop start and hold until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		cfg_t settings[7];
		cmd_t c;
		settings[0] = '{13'd1024, 13'd1024, 13'd64, 13'd64};
		settings[1] = '{13'd1, 13'd1, 13'd1, 13'd1};
		settings[2] = '{13'd4096, 13'd4096, 13'd4096, 13'd4096};
		settings[3] = '{13'd8191, 13'd8191, 13'd8191, 13'd8191};
		settings[4] = '{13'd0, 13'd0, 13'd0, 13'd0};
		settings[5] = '{13'd600, 13'd300, 13'd4096, 13'd7};
		settings[6] = '{13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
			13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096))};

		// Hold reset, then release it at a falling edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under the reset setting: 1024 x 1024 pixels, 64 x 64 blocks.
		// Every orientation on one pixel-mode patch.
		for (int o = ORI_DEFAULT; o <= ORI_SWAP; o++)
			send_cmd(mk_cmd(OP_PIXEL, 7, 9, 2, 3, 4, 5, o, 16));
		// Unknown orientations.
		send_cmd(mk_cmd(OP_PIXEL, 7, 9, 2, 3, 4, 5, 9, 16));
		send_cmd(mk_cmd(OP_PIXEL, 7, 9, 2, 3, 4, 5, 15, 16));
		// Block mode ignores the resolution field.
		send_cmd(mk_cmd(OP_BLOCK, 3, 2, 10, 20, 6, 7, ORI_ROT90, 127));
		send_cmd(mk_cmd(OP_BLOCK, 3, 2, 10, 20, 6, 7, ORI_MROT90, 0));
		// Zero resolution: flipped axes go negative, plain ones stay valid.
		send_cmd(mk_cmd(OP_PIXEL, 5, 6, 9, 9, 3, 3, ORI_ROT180, 0));
		send_cmd(mk_cmd(OP_PIXEL, 5, 6, 9, 9, 3, 3, ORI_DEFAULT, 0));
		// Resolution above the maximum saturates.
		send_cmd(mk_cmd(OP_PIXEL, 5, 6, 1, 2, 3, 3, ORI_DEFAULT, 100));
		// All-zero, all-ones and near-maximum fields.
		send_cmd(mk_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0, ORI_DEFAULT, 0));
		send_cmd(mk_cmd(OP_BLOCK, 4095, 4095, 4095, 4095, 8191, 8191, 15, 127));
		send_cmd(mk_cmd(OP_PIXEL, 4095, 4095, 4095, 4095, 4096, 4096, ORI_MIRROR, 64));
		// Canvas edges: last column and row are valid, one past is not.
		send_cmd(mk_cmd(OP_PIXEL, 1023, 1023, 0, 0, 1, 1, ORI_DEFAULT, 1));
		send_cmd(mk_cmd(OP_PIXEL, 1024, 0, 0, 0, 1, 1, ORI_DEFAULT, 1));
		send_cmd(mk_cmd(OP_BLOCK, 0, 63, 0, 0, 1, 1, ORI_DEFAULT, 1));
		send_cmd(mk_cmd(OP_BLOCK, 0, 64, 0, 0, 1, 1, ORI_DEFAULT, 1));
		// Flip with empty patch at the origin lands at -1.
		send_cmd(mk_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0, ORI_ROT180, 8));
		drain();

		// Random part: one phase per canvas setting, registers written while idle.
		for (int p = 0; p < 7; p++) begin
			idle_on = 1'b1;
			write_reg(REG_FRAME_W, settings[p].frame_width);
			write_reg(REG_FRAME_H, settings[p].frame_height);
			write_reg(REG_GRID_W, settings[p].block_grid_width);
			write_reg(REG_GRID_H, settings[p].block_grid_height);
			// the full-size canvas phase runs back to back with no gaps
			idle_on = (p != 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 70)
					c = patch_point(cur_cfg);
				else
					c = noise_cmd();
				send_cmd(c);
			end
			drain();
		end

		// Keep the clock running in case of a stray late result.
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
